// File: sv/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;
    localparam int LEN_W   = 11;
    localparam int HDR_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = 2'd0;

    localparam logic             OP_LOOKUP   = 1'b0;
    localparam logic             OP_FRAME    = 1'b1;
    localparam logic [LEN_W-1:0] MIN_ARP_LEN = 11'd28;
    localparam logic [HDR_W-1:0] HW_ETHERNET = 16'd1;
    localparam logic [HDR_W-1:0] PROTO_IPV4  = 16'h0800;
    localparam logic [HDR_W-1:0] OPC_REQUEST = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan;
        logic write;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_frame;
        logic frame_ok;
        logic scan_done;
    } t_dp_sts;

endpackage

// File: sv/arpc_ram.sv
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/arpc_ctrl.sv
`timescale 1ns / 1ps

module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.scan_start = 1'b1;
                if (i_sts.is_frame && !i_sts.frame_ok) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.is_frame ? ST_WRITE : ST_RESULT;
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: sv/arpc_dp.sv
`timescale 1ns / 1ps

module arpc_dp
    import arpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_operation,
    input  logic [IP_W-1:0]       i_lookup_ip,
    input  logic [LEN_W-1:0]      i_payload_length,
    input  logic [HDR_W-1:0]      i_hardware_type,
    input  logic [HDR_W-1:0]      i_protocol_type,
    input  logic [HDR_W-1:0]      i_arp_opcode,
    input  logic [IP_W-1:0]       i_sender_ip,
    input  logic [MAC_W-1:0]      i_sender_mac,
    input  logic [IP_W-1:0]       i_target_ip,
    output logic                  o_done,
    output logic                  o_lookup_hit,
    output logic [MAC_W-1:0]      o_found_mac,
    output logic                  o_request_needed,
    output logic                  o_frame_accepted,
    output logic                  o_reply_valid,
    output logic [MAC_W-1:0]      o_reply_target_mac,
    output logic [IP_W-1:0]       o_reply_target_ip
);

    logic [IP_W-1:0]          r_own_ip;
    logic                     r_is_frame;
    logic                     r_frame_ok;
    logic                     r_reply_req;
    logic [IP_W-1:0]          r_key_ip;
    logic [MAC_W-1:0]         r_smac;

    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]         r_next_slot;
    logic [CNT_W-1:0]         r_rd_cnt;
    logic                     r_cmp_vld;
    logic [IDX_W-1:0]         r_cmp_idx;
    logic                     r_found;
    logic [IDX_W-1:0]         r_found_idx;
    logic [MAC_W-1:0]         r_found_mac;

    logic                     r_done;
    logic                     r_lookup_hit;
    logic [MAC_W-1:0]         r_found_mac_out;
    logic                     r_request_needed;
    logic                     r_frame_accepted;
    logic                     r_reply_valid;
    logic [MAC_W-1:0]         r_reply_target_mac;
    logic [IP_W-1:0]          r_reply_target_ip;

    logic                     ram_re;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic                     match;
    logic                     frame_ok_in;
    logic                     reply_in;

    assign frame_ok_in = (i_payload_length >= MIN_ARP_LEN) &&
                         (i_hardware_type == HW_ETHERNET) &&
                         (i_protocol_type == PROTO_IPV4);
    assign reply_in    = (i_arp_opcode == OPC_REQUEST) && (r_own_ip != '0) &&
                         (i_target_ip == r_own_ip);

    assign ram_re    = i_cmd.scan && (r_rd_cnt < CNT_W'(CACHE_ENTRIES));
    assign ram_waddr = r_found ? r_found_idx : r_next_slot;
    assign match     = r_cmp_vld && r_valid[r_cmp_idx] &&
                       (ram_rdata[ENTRY_W-1:MAC_W] == r_key_ip);

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_cache (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (ram_waddr),
        .i_wdata ({r_key_ip, r_smac}),
        .i_re    (ram_re),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_OWN_IP)) begin
            r_own_ip <= i_cfg_data[IP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_frame  <= (i_operation == OP_FRAME);
            r_frame_ok  <= frame_ok_in;
            r_reply_req <= reply_in;
            r_key_ip    <= (i_operation == OP_FRAME) ? i_sender_ip : i_lookup_ip;
            r_smac      <= i_sender_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_cmp_vld <= ram_re;
            if (ram_re) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            if (match && !r_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_cmp_idx <= r_rd_cnt[IDX_W-1:0];
        end
        if (match && !r_found) begin
            r_found_idx <= r_cmp_idx;
            r_found_mac <= ram_rdata[MAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_next_slot <= '0;
        end else if (i_cmd.write && !r_found) begin
            r_valid[r_next_slot] <= 1'b1;
            r_next_slot <= (r_next_slot == IDX_W'(CACHE_ENTRIES - 1)) ?
                           '0 : r_next_slot + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_lookup_hit       <= !r_is_frame && r_found;
            r_found_mac_out    <= (!r_is_frame && r_found) ? r_found_mac : '0;
            r_request_needed   <= !r_is_frame && !r_found;
            r_frame_accepted   <= r_is_frame && r_frame_ok;
            r_reply_valid      <= r_is_frame && r_frame_ok && r_reply_req;
            r_reply_target_mac <= (r_is_frame && r_frame_ok && r_reply_req) ? r_smac : '0;
            r_reply_target_ip  <= (r_is_frame && r_frame_ok && r_reply_req) ?
                                  r_key_ip : '0;
        end
    end

    assign o_sts.is_frame  = r_is_frame;
    assign o_sts.frame_ok  = r_frame_ok;
    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == IDX_W'(CACHE_ENTRIES - 1));

    assign o_done             = r_done;
    assign o_lookup_hit       = r_lookup_hit;
    assign o_found_mac        = r_found_mac_out;
    assign o_request_needed   = r_request_needed;
    assign o_frame_accepted   = r_frame_accepted;
    assign o_reply_valid      = r_reply_valid;
    assign o_reply_target_mac = r_reply_target_mac;
    assign o_reply_target_ip  = r_reply_target_ip;

`ifndef SYNTH
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.write && ram_re))
        else $error("cache read and write in the same cycle");

    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && i_cmd.write) |-> r_valid[r_found_idx])
        else $error("in-place update of an invalid entry");

    a_beat_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_lookup_hit || o_request_needed) != (o_frame_accepted || r_is_frame)
                    || !o_frame_accepted))
        else $error("result beat mixes lookup and frame flags");

    a_reply_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_reply_valid) |-> o_frame_accepted)
        else $error("reply without accepted frame");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= CNT_W'(CACHE_ENTRIES))
        else $error("scan counter past cache depth");
`endif

endmodule

// File: sv/arp_cache_and_responder_core.sv
`timescale 1ns / 1ps
// Steps: load, check, cache walk, entry write (accepted frame only), result; a rejected
// frame skips walk and write. A new item is taken the cycle o_done rises.
// The cache walk reads one entry per cycle through the single RAM read port (16 entries).
// Receiver cannot stall: o_done and the result ports are valid for one cycle.
// Synchronous active-low reset clears valid marks, replacement pointer and own_ip.

module arp_cache_and_responder_core
    import arpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_operation,
    input  logic [IP_W-1:0]       i_lookup_ip,
    input  logic [LEN_W-1:0]      i_payload_length,
    input  logic [HDR_W-1:0]      i_hardware_type,
    input  logic [HDR_W-1:0]      i_protocol_type,
    input  logic [HDR_W-1:0]      i_arp_opcode,
    input  logic [IP_W-1:0]       i_sender_ip,
    input  logic [MAC_W-1:0]      i_sender_mac,
    input  logic [IP_W-1:0]       i_target_ip,
    output logic                  o_done,
    output logic                  o_lookup_hit,
    output logic [MAC_W-1:0]      o_found_mac,
    output logic                  o_request_needed,
    output logic                  o_frame_accepted,
    output logic                  o_reply_valid,
    output logic [MAC_W-1:0]      o_reply_target_mac,
    output logic [IP_W-1:0]       o_reply_target_ip
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    arpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    arpc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_lookup_ip        (i_lookup_ip),
        .i_payload_length   (i_payload_length),
        .i_hardware_type    (i_hardware_type),
        .i_protocol_type    (i_protocol_type),
        .i_arp_opcode       (i_arp_opcode),
        .i_sender_ip        (i_sender_ip),
        .i_sender_mac       (i_sender_mac),
        .i_target_ip        (i_target_ip),
        .o_done             (o_done),
        .o_lookup_hit       (o_lookup_hit),
        .o_found_mac        (o_found_mac),
        .o_request_needed   (o_request_needed),
        .o_frame_accepted   (o_frame_accepted),
        .o_reply_valid      (o_reply_valid),
        .o_reply_target_mac (o_reply_target_mac),
        .o_reply_target_ip  (o_reply_target_ip)
    );

endmodule
